// ===== design/ppiu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppiu_pkg
// Shared types, constants and the slots-per-word table of the palette index
// unpacker.
// ----------------------------------------------------------------------------
package ppiu_pkg;

  localparam int BLOCKS_PER_STORAGE_DEF = 4096;
  localparam int QUEUE_DEPTH            = 2;

  localparam int WORD_W   = 32;
  localparam int WIDTH_W  = 5;
  localparam int SLOT_W   = 6;
  localparam int INDEX_W  = 16;
  localparam int HEIGHT_W = 8;
  localparam int CFG_IDX_W = 8;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH = 5'd1;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_BLOCK   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_CHUNK_HEIGHT = 8'd1;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [WIDTH_W-1:0] width;
    logic [SLOT_W-1:0]  per_word;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  palette_index;
    logic [3:0]          block_x;
    logic signed [11:0]  block_y;
    logic [3:0]          block_z;
    logic                last_of_word;
    logic                last_of_storage;
  } result_t;

  // Number of whole indices in one 32-bit word for a clamped width.
  function automatic logic [SLOT_W-1:0] per_word_of(input logic [WIDTH_W-1:0] w);
    logic [SLOT_W-1:0] n;
    case (w)
      5'd1:    n = 6'd32;
      5'd2:    n = 6'd16;
      5'd3:    n = 6'd10;
      5'd4:    n = 6'd8;
      5'd5:    n = 6'd6;
      5'd6:    n = 6'd5;
      5'd7:    n = 6'd4;
      5'd8:    n = 6'd4;
      5'd9:    n = 6'd3;
      5'd10:   n = 6'd3;
      default: n = 6'd2;
    endcase
    return n;
  endfunction

endpackage

// ===== design/ppiu_front.sv =====
// ----------------------------------------------------------------------------
// ppiu_front
// Accepts storage words and tags each with its clamped index width and the
// number of slots it holds before queueing it.
// ----------------------------------------------------------------------------
module ppiu_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ppiu_pkg::WORD_W-1:0]     s_tdata,
  input  logic [ppiu_pkg::WIDTH_W-1:0]    bits_per_block,
  input  ppiu_pkg::queue_status_t         q_status,
  output logic                            push,
  output ppiu_pkg::queue_entry_t          push_entry
);
  import ppiu_pkg::*;

  logic [WIDTH_W-1:0] width;

  always_comb begin
    if (bits_per_block == '0) begin
      width = MIN_WIDTH;
    end else if (bits_per_block > MAX_WIDTH) begin
      width = MAX_WIDTH;
    end else begin
      width = bits_per_block;
    end
  end

  assign s_tready            = !q_status.full;
  assign push                = s_tvalid && !q_status.full;
  assign push_entry.word     = s_tdata;
  assign push_entry.width    = width;
  assign push_entry.per_word = per_word_of(width);

endmodule

// ===== design/ppiu_queue.sv =====
// ----------------------------------------------------------------------------
// ppiu_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module ppiu_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ppiu_pkg::queue_entry_t  push_entry,
  input  logic                    pop,
  output ppiu_pkg::queue_entry_t  pop_entry,
  output ppiu_pkg::queue_status_t q_status
);
  import ppiu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_entry      = entries[rd_ptr];
  assign q_status.full  = (count == FULL_CNT);
  assign q_status.empty = (count == '0);

endmodule

// ===== design/ppiu_back.sv =====
// ----------------------------------------------------------------------------
// ppiu_back
// Unpacks one queued word, one index per unstalled cycle, stamps each index
// with the block coordinates and drives the registered result channel.
// ----------------------------------------------------------------------------
module ppiu_back #(
  parameter int BLOCKS_PER_STORAGE = ppiu_pkg::BLOCKS_PER_STORAGE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppiu_pkg::queue_entry_t            pop_entry,
  input  ppiu_pkg::queue_status_t           q_status,
  output logic                              pop,
  input  logic signed [ppiu_pkg::HEIGHT_W-1:0] sub_chunk_height,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output ppiu_pkg::result_t                 m_result
);
  import ppiu_pkg::*;

  localparam int POS_W = $clog2(BLOCKS_PER_STORAGE);
  localparam logic [POS_W-1:0] POS_END = POS_W'(BLOCKS_PER_STORAGE - 1);

  logic               active;
  logic [WORD_W-1:0]  word;
  logic [WIDTH_W-1:0] width;
  logic [SLOT_W-1:0]  remain;
  logic [POS_W-1:0]   pos;
  logic               out_valid;
  result_t            out_reg;

  logic               out_load;
  logic               pos_end;
  logic               last_w;
  logic [INDEX_W-1:0] mask;

  assign out_load = active && (!out_valid || m_tready);
  assign pos_end  = (pos == POS_END);
  assign last_w   = pos_end || (remain == SLOT_W'(1));
  assign mask     = ~({INDEX_W{1'b1}} << width);
  assign pop      = !q_status.empty && (!active || (out_load && last_w));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (out_load && last_w) begin
        active <= 1'b0;
      end
      if (out_load) begin
        pos <= pos_end ? '0 : pos + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word   <= pop_entry.word;
      width  <= pop_entry.width;
      remain <= pop_entry.per_word;
    end else if (out_load) begin
      word   <= word >> width;
      remain <= remain - 1'b1;
    end
  end

  // The height term is a multiple of sixteen, so world y is the height
  // register placed above the local y nibble.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg.palette_index   <= word[INDEX_W-1:0] & mask;
      out_reg.block_x         <= pos[11:8];
      out_reg.block_z         <= pos[7:4];
      out_reg.block_y         <= {sub_chunk_height, pos[3:0]};
      out_reg.last_of_word    <= last_w;
      out_reg.last_of_storage <= pos_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_result = out_reg;

`ifndef SYNTHESIS
  a_wrap_to_zero : assert property (@(posedge clk) disable iff (rst)
    out_load && pos_end |=> pos == '0)
    else $error("position did not wrap after the final block");

  a_slots_left : assert property (@(posedge clk) disable iff (rst)
    active |-> remain != '0)
    else $error("active word with no slots left");

  a_stay_active : assert property (@(posedge clk) disable iff (rst)
    out_load && !last_w |=> active)
    else $error("word dropped before its last slot");

  a_word_end_flag : assert property (@(posedge clk) disable iff (rst)
    out_load && !last_w |=> !(out_valid && out_reg.last_of_word))
    else $error("end of word flagged on an inner slot");
`endif

endmodule

// ===== design/packed_palette_index_unpacker.sv =====
// ----------------------------------------------------------------------------
// packed_palette_index_unpacker
// Unpacks bit-packed palette indices from 32-bit storage words and tags each
// with its x, z and world y position.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    packed word
//  m_*      out        m_tvalid / m_tready    index, x, y, z, tlast, tuser
//  cfg_*    in         cfg_valid / cfg_ready  register index, write data
//
// A word yields one result per unstalled cycle, 32 / width of them (2 to 32),
// fewer at the end of the storage; the front sets it from the package table.
// A two-entry queue takes new words while the back is still unpacking, and
// the output register keeps results moving under downstream stalls.
// Reset clears the position counter, the queue and the output valid; the
// configuration returns to a width of four and a height of zero.
// ----------------------------------------------------------------------------
module packed_palette_index_unpacker #(
  parameter int BLOCKS_PER_STORAGE = ppiu_pkg::BLOCKS_PER_STORAGE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // packed_word
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // palette_index[15:0], block_x[19:16], block_y[31:20], block_z[35:32], zeros
  output logic [39:0]                        m_tdata,
  output logic                               m_tlast,   // last_of_word
  output logic                               m_tuser,   // last_of_storage
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppiu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);
  import ppiu_pkg::*;

  logic [WIDTH_W-1:0]         bits_per_block;
  logic signed [HEIGHT_W-1:0] sub_chunk_height;
  logic                       push;
  logic                       pop;
  queue_entry_t               push_entry;
  queue_entry_t               pop_entry;
  queue_status_t              q_status;
  result_t                    result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_block   <= 5'd4;
      sub_chunk_height <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BITS_PER_BLOCK:   bits_per_block   <= cfg_data[WIDTH_W-1:0];
        REG_SUB_CHUNK_HEIGHT: sub_chunk_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ppiu_front u_front (
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .bits_per_block (bits_per_block),
    .q_status       (q_status),
    .push           (push),
    .push_entry     (push_entry)
  );

  ppiu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  ppiu_back #(
    .BLOCKS_PER_STORAGE (BLOCKS_PER_STORAGE)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_entry        (pop_entry),
    .q_status         (q_status),
    .pop              (pop),
    .sub_chunk_height (sub_chunk_height),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_result         (result)
  );

  assign m_tdata = {4'b0000, result.block_z, result.block_y, result.block_x,
                    result.palette_index};
  assign m_tlast = result.last_of_word;
  assign m_tuser = result.last_of_storage;

endmodule

// ===== tb/tb_packed_palette_index_unpacker.sv =====
// ----------------------------------------------------------------------------
// tb_packed_palette_index_unpacker
// Streams storage words into the palette index unpacker and checks every
// unpacked block against a scoreboard that tracks the position counter and
// the configuration. A directed opening covers the widths and heights at
// their extremes. Random phases follow, and some of them run the counter up
// to the end of a storage so that the padding slots are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class palette_index_scoreboard;
  logic [4:0]        width_reg;
  logic [7:0]        height_reg;
  logic [11:0]       position;
  ppiu_pkg::result_t expected_blocks[$];
  int unsigned       errors;

  function new();
    width_reg  = 5'd4;
    height_reg = 8'd0;
    position   = 12'd0;
    errors     = 0;
  endfunction

  function void write_reg(input logic [7:0] idx, input logic [7:0] data);
    case (idx)
      ppiu_pkg::REG_BITS_PER_BLOCK:   width_reg  = data[4:0];
      ppiu_pkg::REG_SUB_CHUNK_HEIGHT: height_reg = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_blocks.size();
  endfunction

  // Expands one accepted word into the blocks it is expected to produce.
  function void note_word(input logic [31:0] word);
    int                width;
    int                slots;
    logic [11:0]       y_offset;
    ppiu_pkg::result_t r;
    width    = (width_reg == 0) ? 1 : ((width_reg > 16) ? 16 : int'(width_reg));
    slots    = 32 / width;
    // Sign-extended height times sixteen, reduced to twelve bits.
    y_offset = {height_reg, 4'b0000};
    for (int s = 0; s < slots; s++) begin
      r.palette_index   = 16'((word >> (s * width)) & ((32'd1 << width) - 32'd1));
      r.block_x         = position[11:8];
      r.block_z         = position[7:4];
      r.block_y         = {8'd0, position[3:0]} + y_offset;
      r.last_of_storage = (position == 12'hFFF);
      r.last_of_word    = r.last_of_storage || (s == slots - 1);
      expected_blocks.push_back(r);
      position = position + 12'd1;
      // The rest of the word is padding once the storage is complete.
      if (r.last_of_storage) break;
    end
  endfunction

  function void check_block(input ppiu_pkg::result_t got);
    ppiu_pkg::result_t want;
    if (expected_blocks.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected block: index %h x %h y %h z %h tlast %b tuser %b",
                 got.palette_index, got.block_x, got.block_y, got.block_z,
                 got.last_of_word, got.last_of_storage);
    end else begin
      want = expected_blocks.pop_front();
      if (got.palette_index !== want.palette_index || got.block_x !== want.block_x ||
          got.block_y !== want.block_y || got.block_z !== want.block_z ||
          got.last_of_word !== want.last_of_word ||
          got.last_of_storage !== want.last_of_storage) begin
        errors++;
        if (errors <= 10)
          $display("block mismatch: expected %h %h %h %h %b %b, got %h %h %h %h %b %b",
                   want.palette_index, want.block_x, want.block_y, want.block_z,
                   want.last_of_word, want.last_of_storage,
                   got.palette_index, got.block_x, got.block_y, got.block_z,
                   got.last_of_word, got.last_of_storage);
      end
    end
  endfunction
endclass

module tb_packed_palette_index_unpacker;
  import ppiu_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_WORDS  = 385;
  localparam int QUIET_FROM    = 330;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;   // packed_word
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  // palette_index[15:0], block_x[19:16], block_y[31:20], block_z[35:32], zeros
  logic [39:0] m_tdata;
  logic        m_tlast;          // last_of_word
  logic        m_tuser;          // last_of_storage
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  logic        quiet          = 1'b0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int          hold_left      = 0;
  int          cycle_count    = 0;
  result_t     seen;

  palette_index_scoreboard sb = new();

  packed_palette_index_unpacker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: checks each transaction and inserts random stall bursts,
  // plus one long hold that backs the block up into its input.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.palette_index   = m_tdata[15:0];
      seen.block_x         = m_tdata[19:16];
      seen.block_y         = m_tdata[31:20];
      seen.block_z         = m_tdata[35:32];
      seen.last_of_word    = m_tlast;
      seen.last_of_storage = m_tuser;
      sb.check_block(seen);
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD - 1;
      m_tready       <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 5);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [31:0] word);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.note_word(word);
  endtask

  task automatic wait_idle(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] width_data, input logic [7:0] height_data);
    wait_idle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BITS_PER_BLOCK;
    cfg_data  <= width_data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_BITS_PER_BLOCK, width_data);
    cfg_index <= REG_SUB_CHUNK_HEIGHT;
    cfg_data  <= height_data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_SUB_CHUNK_HEIGHT, height_data);
    cfg_valid <= 1'b0;
  endtask

  // Fills the storage with one-bit words, then finishes it with a wider
  // width so that the last word usually carries padding past block 4095.
  task automatic run_storage_end(inout int count);
    int remaining;
    int width;
    int tries;
    configure({3'($urandom_range(0, 7)), 5'd1}, 8'($urandom_range(0, 255)));
    if (!long_hold_req) long_hold_req <= 1'b1;
    remaining = 4096 - int'(sb.position);
    while (remaining > 40) begin
      send_word(random_word());
      count++;
      remaining = 4096 - int'(sb.position);
    end
    tries = 0;
    do begin
      width = $urandom_range(3, 15);
      tries++;
    end while ((remaining % (32 / width)) == 0 && tries < 8);
    configure(8'(width), 8'($urandom_range(0, 255)));
    do begin
      send_word(random_word());
      count++;
    end while (sb.position != 12'd0);
  endtask

  initial begin
    int sent;
    int unsigned n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: width four, height zero.
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7654_3210);
    // Narrowest width with the highest sub-chunk.
    configure(8'h01, 8'h7F);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    // Widest width with the lowest sub-chunk.
    configure(8'h10, 8'h80);
    send_word(32'hFFFF_0000);
    send_word(32'h0000_FFFF);
    // Out-of-range widths: zero acts as one, anything above sixteen as sixteen.
    configure(8'h00, 8'hFF);
    send_word(32'h8000_0001);
    configure(8'h11, 8'h40);
    send_word(32'h1234_5678);
    configure(8'hFF, 8'h01);
    send_word(32'hDEAD_BEEF);
    for (int w = 2; w <= 15; w++) begin
      if (w != 4) begin
        configure({3'($urandom_range(0, 7)), 5'(w)}, 8'($urandom_range(0, 255)));
        send_word((w % 2 == 1) ? 32'hFFFF_FFFF : 32'($urandom()));
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= QUIET_FROM) quiet <= 1'b1;
      if (sent == 0 || (sent < 250 && $urandom_range(0, 5) == 0)) begin
        run_storage_end(sent);
      end else begin
        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        n = $urandom_range(8, 30);
        repeat (n) begin
          send_word(random_word());
          sent++;
        end
      end
    end

    wait_idle(TAIL_CYCLES);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
